### rtl/scfr_pkg.sv
// scfr_pkg: shared types and constants of the sum checked frame receiver
// no dependencies; imported by the parser, the output buffer and the top level
package scfr_pkg;

  // largest payload length that is accepted
  localparam int unsigned MAX_PAYLOAD = 128;

  localparam logic [7:0] PRE1_BYTE  = 8'hAA;
  localparam logic [7:0] PRE2_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_CMD_A = 8'h10;
  localparam logic [7:0] TYPE_CMD_B = 8'h11;
  localparam logic [7:0] TYPE_TELEM = 8'h20;
  // reply word for a telemetry request, sent by downstream logic
  localparam logic [7:0] TELEM_REPLY = 8'hFF;

  typedef enum logic [2:0] {
    PH_PRE1 = 3'd0,
    PH_PRE2 = 3'd1,
    PH_VER  = 3'd2,
    PH_TYPE = 3'd3,
    PH_ID   = 3'd4,
    PH_LEN  = 3'd5,
    PH_PAY  = 3'd6,
    PH_CHK  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_TELEM   = 3'd2,
    EV_UNKNOWN = 3'd3,
    EV_BUSY    = 3'd4,
    EV_CSUM    = 3'd5
  } event_t;

  // one result word
  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [7:0] out_version;
    logic [7:0] out_type;
    logic [7:0] out_id;
    logic [7:0] out_length;
  } result_t;

endpackage

### rtl/scfr_ifs.sv
// scfr_ifs: valid/ready channel interfaces for received bytes and result words
// no dependencies
interface scfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       busy_req;

  modport source (output valid, output rx_byte, output busy_req, input ready);
  modport sink   (input valid, input rx_byte, input busy_req, output ready);
endinterface

interface scfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [6:0] byte_index;
  logic [7:0] out_version;
  logic [7:0] out_type;
  logic [7:0] out_id;
  logic [7:0] out_length;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output out_version, output out_type, output out_id,
                  output out_length, input ready);
  modport sink   (input valid, input event_res, input data_byte, input byte_index,
                  input out_version, input out_type, input out_id,
                  input out_length, output ready);
endinterface

### rtl/scfr_parser.sv
// scfr_parser: frame state machine, header registers and running sum
// depends on scfr_pkg
module scfr_parser
  import scfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       busy_req,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] frame_version, frame_version_next;
  logic [7:0] frame_type, frame_type_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] sum_add;
  logic [7:0] count_inc;
  event_t     verdict;

  assign sum_add   = running_sum + rx_byte;
  assign count_inc = payload_count + 8'd1;

  // verdict on the checksum byte
  always_comb begin
    if (rx_byte != running_sum) begin
      verdict = EV_CSUM;
    end else if (busy_req) begin
      verdict = EV_BUSY;
    end else if (frame_type == TYPE_CMD_A || frame_type == TYPE_CMD_B) begin
      verdict = EV_ACCEPT;
    end else if (frame_type == TYPE_TELEM) begin
      verdict = EV_TELEM;
    end else begin
      verdict = EV_UNKNOWN;
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    frame_version_next = frame_version;
    frame_type_next    = frame_type;
    frame_id_next      = frame_id;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    case (phase)
      PH_PRE1: begin
        if (rx_byte == PRE1_BYTE) phase_next = PH_PRE2;
      end
      PH_PRE2: begin
        if (rx_byte == PRE2_BYTE) phase_next = PH_VER;
        else if (rx_byte == PRE1_BYTE) phase_next = PH_PRE2;
        else phase_next = PH_PRE1;
      end
      PH_VER: begin
        frame_version_next = rx_byte;
        running_sum_next   = rx_byte;
        phase_next         = PH_TYPE;
      end
      PH_TYPE: begin
        frame_type_next  = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        frame_id_next    = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        frame_length_next = rx_byte;
        running_sum_next  = sum_add;
        if (rx_byte == 8'd0) begin
          phase_next = PH_CHK;
        end else if (rx_byte > 8'(MAX_PAYLOAD)) begin
          phase_next = PH_PRE1;
        end else begin
          payload_count_next = 8'd0;
          phase_next         = PH_PAY;
        end
      end
      PH_PAY: begin
        running_sum_next   = sum_add;
        payload_count_next = count_inc;
        if (count_inc >= frame_length) phase_next = PH_CHK;
      end
      PH_CHK: begin
        phase_next = PH_PRE1;
      end
      default: begin
        phase_next = PH_PRE1;
      end
    endcase
  end

  // result word for the byte on the input
  always_comb begin
    res.out_version = frame_version;
    res.out_type    = frame_type;
    res.out_id      = frame_id;
    res.out_length  = frame_length;
    case (phase)
      PH_PAY: begin
        res_valid      = take;
        res.event_res  = EV_PAYLOAD;
        res.data_byte  = rx_byte;
        res.byte_index = payload_count[6:0];
      end
      PH_CHK: begin
        res_valid      = take;
        res.event_res  = verdict;
        res.data_byte  = 8'd0;
        res.byte_index = 7'd0;
      end
      default: begin
        res_valid      = 1'b0;
        res.event_res  = EV_PAYLOAD;
        res.data_byte  = 8'd0;
        res.byte_index = 7'd0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PRE1;
      frame_version <= 8'd0;
      frame_type    <= 8'd0;
      frame_id      <= 8'd0;
      frame_length  <= 8'd0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
    end else if (take) begin
      phase         <= phase_next;
      frame_version <= frame_version_next;
      frame_type    <= frame_type_next;
      frame_id      <= frame_id_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

### rtl/scfr_out_buf.sv
// scfr_out_buf: result register with a skid stage behind it
// depends on scfr_pkg
module scfr_out_buf
  import scfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  result_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output result_t dn_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_word;
  result_t skid_word;
  logic    push;
  logic    main_free;

  assign up_ready  = !skid_valid;
  assign push      = up_valid && up_ready;
  assign main_free = !main_valid || dn_ready;
  assign dn_valid  = main_valid;
  assign dn_data   = main_word;

  // occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) main_word <= skid_word;
      else if (push) main_word <= up_data;
    end else if (push) begin
      skid_word <= up_data;
    end
  end

endmodule

### rtl/sum_checked_frame_receiver.sv
// sum_checked_frame_receiver: top level of the preamble framed byte receiver
// depends on scfr_pkg, scfr_ifs, scfr_parser and scfr_out_buf
//
// channel  dir  contents
// rx       in   rx_byte, busy_req: one received word
// res      out  event_res, data_byte, byte_index, header fields: one result word
//
// one received word is taken per cycle while rx.ready is high; the frame
// state updates in that cycle and a payload or verdict word lands in the result
// register (or in the skid stage when res stalls) on the next edge.
// rx.ready drops only when both the result register and the skid stage hold
// words, so a stall on res stops the input two results later.
// synchronous reset returns the parser to preamble hunting and empties the buffer.
module sum_checked_frame_receiver
  import scfr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  scfr_rx_if.sink  rx,
  scfr_res_if.source res
);

  logic    take;
  logic    buf_ready;
  logic    par_valid;
  result_t par_word;
  result_t out_word;

  assign rx.ready = buf_ready;
  assign take     = rx.valid && buf_ready;

  scfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx.rx_byte),
    .busy_req  (rx.busy_req),
    .res_valid (par_valid),
    .res       (par_word)
  );

  scfr_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .up_valid (par_valid),
    .up_ready (buf_ready),
    .up_data  (par_word),
    .dn_valid (res.valid),
    .dn_ready (res.ready),
    .dn_data  (out_word)
  );

  // result word onto the channel
  assign res.event_res   = out_word.event_res;
  assign res.data_byte   = out_word.data_byte;
  assign res.byte_index  = out_word.byte_index;
  assign res.out_version = out_word.out_version;
  assign res.out_type    = out_word.out_type;
  assign res.out_id      = out_word.out_id;
  assign res.out_length  = out_word.out_length;

endmodule

### tb/frame_tracker_pkg.sv
// frame_tracker_pkg: tracks the frame parse from accepted received words,
// keeps the awaited result words and checks each result word against them
// depends on scfr_pkg for the phase, event and result word types
package frame_tracker_pkg;
  import scfr_pkg::*;

  class frame_tracker;
    phase_t     phase;
    logic [7:0] version;
    logic [7:0] ftype;
    logic [7:0] id;
    logic [7:0] length;
    logic [7:0] count;
    logic [7:0] sum;
    result_t    awaited_words[$];
    int         errors;

    function new();
      phase   = PH_PRE1;
      version = '0;
      ftype   = '0;
      id      = '0;
      length  = '0;
      count   = '0;
      sum     = '0;
      errors  = 0;
    endfunction

    // queue one awaited result word carrying the current header
    function void await_word(event_t ev, logic [7:0] data, logic [6:0] index);
      result_t w;
      w.event_res   = ev;
      w.data_byte   = data;
      w.byte_index  = index;
      w.out_version = version;
      w.out_type    = ftype;
      w.out_id      = id;
      w.out_length  = length;
      awaited_words.push_back(w);
    endfunction

    // advance the parse by one accepted received word
    function void take_rx_word(logic [7:0] b, logic busy);
      case (phase)
        PH_PRE1: begin
          if (b == PRE1_BYTE) phase = PH_PRE2;
        end
        PH_PRE2: begin
          if (b == PRE2_BYTE) phase = PH_VER;
          else if (b == PRE1_BYTE) phase = PH_PRE2;
          else phase = PH_PRE1;
        end
        PH_VER: begin
          version = b;
          sum     = b;
          phase   = PH_TYPE;
        end
        PH_TYPE: begin
          ftype = b;
          sum   = sum + b;
          phase = PH_ID;
        end
        PH_ID: begin
          id    = b;
          sum   = sum + b;
          phase = PH_LEN;
        end
        PH_LEN: begin
          length = b;
          sum    = sum + b;
          if (b == 8'd0) begin
            phase = PH_CHK;
          end else if (b > MAX_PAYLOAD) begin
            // oversized frame is dropped without a word
            phase = PH_PRE1;
          end else begin
            count = '0;
            phase = PH_PAY;
          end
        end
        PH_PAY: begin
          sum = sum + b;
          await_word(EV_PAYLOAD, b, count[6:0]);
          count = count + 8'd1;
          if (count >= length) phase = PH_CHK;
        end
        default: begin
          // checksum word: sum error wins over busy, busy wins over type
          if (b != sum) await_word(EV_CSUM, 8'd0, 7'd0);
          else if (busy) await_word(EV_BUSY, 8'd0, 7'd0);
          else if (ftype == TYPE_CMD_A || ftype == TYPE_CMD_B)
            await_word(EV_ACCEPT, 8'd0, 7'd0);
          else if (ftype == TYPE_TELEM) await_word(EV_TELEM, 8'd0, 7'd0);
          else await_word(EV_UNKNOWN, 8'd0, 7'd0);
          phase = PH_PRE1;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 50)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // check one accepted result word against the oldest awaited one
    function void match_result_word(result_t got);
      result_t want;
      if (awaited_words.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: result word with none awaited, expected none, actual %0h",
                   $time, got);
        return;
      end
      want = awaited_words.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("out_version", want.out_version, got.out_version);
      compare_field("out_type", want.out_type, got.out_type);
      compare_field("out_id", want.out_id, got.out_id);
      compare_field("out_length", want.out_length, got.out_length);
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction
  endclass

endpackage

### tb/sum_checked_frame_receiver_tb.sv
// sum_checked_frame_receiver_tb: drives framed byte streams with random gaps and
// stalls into the receiver and checks every result word against the frame tracker
// depends on scfr_pkg, scfr_ifs, frame_tracker_pkg and the receiver rtl
module sum_checked_frame_receiver_tb;
  import scfr_pkg::*;
  import frame_tracker_pkg::*;

  localparam int RANDOM_WORDS = 2000;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst;
  bit   calm;
  bit   hold_req;
  int   cycle_count;
  int   frame_words;

  frame_tracker tracker = new();

  scfr_rx_if  rx_ch ();
  scfr_res_if res_ch ();

  sum_checked_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reset and known values on every input
  initial begin
    rst            <= 1'b1;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_byte  <= 8'd0;
    rx_ch.busy_req <= 1'b0;
    res_ch.ready   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // stretches with and without idling
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ($urandom_range(0, 2) == 0);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // note accepted words on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready)
        tracker.take_rx_word(rx_ch.rx_byte, rx_ch.busy_req);
      if (res_ch.valid && res_ch.ready)
        tracker.match_result_word(result_t'{
          event_res:   res_ch.event_res,
          data_byte:   res_ch.data_byte,
          byte_index:  res_ch.byte_index,
          out_version: res_ch.out_version,
          out_type:    res_ch.out_type,
          out_id:      res_ch.out_id,
          out_length:  res_ch.out_length});
    end
  end

  // result side: random stalls plus one long hold on request
  initial begin : result_sink
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        hold_req     <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // offer one received word, return once it is taken
  task automatic send_word(input logic [7:0] b, input logic busy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid    <= 1'b1;
    rx_ch.rx_byte  <= b;
    rx_ch.busy_req <= busy;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  // one frame; fill below zero gives random payload, else a constant byte
  task automatic send_frame(input int pre_count, input logic [7:0] ver,
                            input logic [7:0] ftype, input logic [7:0] id,
                            input logic [7:0] len, input bit corrupt, input bit busy,
                            input int fill);
    logic [7:0] csum;
    logic [7:0] b;
    repeat (pre_count) send_word(PRE1_BYTE, 1'($urandom));
    send_word(PRE2_BYTE, 1'($urandom));
    send_word(ver, 1'($urandom));
    send_word(ftype, 1'($urandom));
    send_word(id, 1'($urandom));
    send_word(len, 1'($urandom));
    frame_words += pre_count + 5;
    if (len > MAX_PAYLOAD) return;
    csum = ver + ftype + id + len;
    repeat (len) begin
      b    = (fill < 0) ? 8'($urandom) : 8'(fill);
      csum = csum + b;
      send_word(b, 1'($urandom));
    end
    if (corrupt) csum = csum + 8'($urandom_range(1, 255));
    send_word(csum, busy);
    frame_words += len + 1;
  endtask

  // stop offering until every awaited word has come
  task automatic drain();
    rx_ch.valid <= 1'b0;
    // wait so the last accepted word is already noted by the tracker
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int         frame_no;
    int         r;
    logic [7:0] ftype;
    logic [7:0] len;
    logic [7:0] nb;
    while (rst !== 1'b0) @(posedge clk);

    // directed: preamble cases, every verdict, header and length extremes
    send_word(PRE1_BYTE, 1'b0);
    send_word(8'h12, 1'b0);
    send_frame(3, 8'h00, TYPE_CMD_A, 8'h00, 8'd0, 1'b0, 1'b0, -1);
    send_frame(1, 8'hFF, TYPE_CMD_B, 8'hFF, 8'd1, 1'b0, 1'b0, 8'h00);
    send_frame(1, 8'h5A, TYPE_TELEM, 8'h01, 8'(MAX_PAYLOAD), 1'b0, 1'b0, 8'hFF);
    send_frame(1, 8'h01, 8'h00, 8'h7E, 8'd2, 1'b0, 1'b0, -1);
    send_frame(1, 8'h02, 8'hFF, 8'h80, 8'd0, 1'b0, 1'b0, -1);
    send_frame(1, 8'h03, TYPE_CMD_A, 8'h04, 8'd3, 1'b0, 1'b1, -1);
    send_frame(1, 8'h03, TYPE_CMD_B, 8'h04, 8'd3, 1'b1, 1'b1, -1);
    send_frame(2, 8'h03, TYPE_TELEM, 8'h05, 8'd0, 1'b1, 1'b0, -1);
    send_frame(1, 8'h06, TYPE_CMD_A, 8'h07, 8'(MAX_PAYLOAD + 1), 1'b0, 1'b0, -1);
    send_frame(1, 8'h06, TYPE_CMD_A, 8'h07, 8'hFF, 1'b0, 1'b0, -1);
    send_frame(1, 8'hA5, TYPE_TELEM, 8'hAA, 8'd1, 1'b0, 1'b1, 8'hAA);
    drain();

    // random: mostly well-formed frames, some noise and cut-off headers
    frame_words = 0;
    frame_no    = 0;
    while (frame_words < RANDOM_WORDS) begin
      frame_no++;
      if (frame_no == 40) begin
        // long result hold while words keep coming
        hold_req <= 1'b1;
        send_frame(1, 8'($urandom), TYPE_CMD_A, 8'($urandom), 8'd60, 1'b0, 1'b0, -1);
      end else if (frame_no == 80 || $urandom_range(0, 49) == 0) begin
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0:       nb = PRE1_BYTE;
            1:       nb = PRE2_BYTE;
            default: nb = 8'($urandom);
          endcase
          send_word(nb, 1'($urandom));
        end
      end else if (r < 15) begin
        // header cut short, the next frame runs into it
        send_word(PRE1_BYTE, 1'($urandom));
        send_word(PRE2_BYTE, 1'($urandom));
        repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       ftype = TYPE_CMD_A;
          1:       ftype = TYPE_CMD_B;
          2:       ftype = TYPE_TELEM;
          default: ftype = 8'($urandom);
        endcase
        r = $urandom_range(0, 99);
        if (r < 70) len = 8'($urandom_range(0, 8));
        else if (r < 90) len = 8'($urandom_range(9, 40));
        else if (r < 96) len = 8'($urandom_range(41, MAX_PAYLOAD));
        else len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        send_frame(($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1,
                   8'($urandom), ftype, 8'($urandom), len,
                   $urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0, -1);
      end
    end

    // drain and let the pipeline settle
    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
